>>> rtl/max_heap_priority_queue_assert.svh
// Assertion macros for the max-heap priority queue checker.
// No dependencies; included by the checker file.
`ifndef MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define MHPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mhpq assertion failed");

// Next-cycle implication, disabled while rst is high.
`define MHPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mhpq assertion failed");

`endif

>>> rtl/mhpq_pkg.sv
// Shared types and constants of the max-heap priority queue.
// No dependencies; imported by the RTL modules, the checker and the testbench.
`timescale 1ns / 1ps

package mhpq_pkg;

   localparam int DATA_W       = 32;
   localparam int STATUS_W     = 2;
   localparam int TOTAL_W      = 8;
   localparam int CAPACITY_DEF = 128;

   localparam logic CMD_INSERT  = 1'b0;
   localparam logic CMD_EXTRACT = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic                     cmd;
      logic signed [DATA_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic [STATUS_W-1:0]      status;
      logic [TOTAL_W-1:0]       entry_total;
   } rsp_item_type;

   // controller -> datapath
   typedef struct packed {
      logic start_ins;
      logic start_ext;
      logic set_full;
      logic set_empty;
      logic rd_up;
      logic rd_down;
      logic ext_load;
      logic wr_key;
      logic up_move;
      logic dn_move;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic empty;
      logic at_root;
      logic no_child;
      logic up_swap;
      logic dn_swap;
   } dp_stat_type;

endpackage

>>> rtl/mhpq_stream_if.sv
// Valid/ready channel carrying one item per handshake.
// Item type comes from mhpq_pkg at instantiation.
`timescale 1ns / 1ps

interface mhpq_stream_if #(
   parameter type item_type = logic
);
   logic     valid;
   logic     ready;
   item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

>>> rtl/mhpq_ctrl.sv
// Sequencer for insert / extract and the sift loops.
// Depends on mhpq_pkg; drives mhpq_datapath through dp_cmd_type.
`timescale 1ns / 1ps

module mhpq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_cmd,
   output logic                 req_ready,
   input  logic                 out_free,
   output logic                 out_load,
   input  mhpq_pkg::dp_stat_type stat,
   output mhpq_pkg::dp_cmd_type  cmd
);
   import mhpq_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_UP_RD   = 7'b0000010,
      S_UP_CMP  = 7'b0000100,
      S_EX_LOAD = 7'b0001000,
      S_DN_RD   = 7'b0010000,
      S_DN_CMP  = 7'b0100000,
      S_FINISH  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_cmd == CMD_INSERT) begin
                  if (stat.full) begin
                     cmd.set_full = 1'b1;
                     state_in     = S_FINISH;
                  end else begin
                     cmd.start_ins = 1'b1;
                     state_in      = S_UP_RD;
                  end
               end else begin
                  if (stat.empty) begin
                     cmd.set_empty = 1'b1;
                     state_in      = S_FINISH;
                  end else begin
                     cmd.start_ext = 1'b1;
                     state_in      = S_EX_LOAD;
                  end
               end
            end
         end
         S_UP_RD: begin
            if (stat.at_root) begin
               cmd.wr_key = 1'b1;
               state_in   = S_FINISH;
            end else begin
               cmd.rd_up = 1'b1;
               state_in  = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (stat.up_swap) begin
               cmd.up_move = 1'b1;
               state_in    = S_UP_RD;
            end else begin
               cmd.wr_key = 1'b1;
               state_in   = S_FINISH;
            end
         end
         S_EX_LOAD: begin
            cmd.ext_load = 1'b1;
            state_in     = S_DN_RD;
         end
         S_DN_RD: begin
            if (stat.no_child) begin
               cmd.wr_key = 1'b1;
               state_in   = S_FINISH;
            end else begin
               cmd.rd_down = 1'b1;
               state_in    = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            if (stat.dn_swap) begin
               cmd.dn_move = 1'b1;
               state_in    = S_DN_RD;
            end else begin
               cmd.wr_key = 1'b1;
               state_in   = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/mhpq_datapath.sv
// Heap store, entry count, moving key and position of the sift.
// Depends on mhpq_pkg; commanded by mhpq_ctrl.
`timescale 1ns / 1ps

module mhpq_datapath #(
   parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF,
   parameter int IW       = $clog2(CAPACITY + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic signed [mhpq_pkg::DATA_W-1:0] req_value,
   input  mhpq_pkg::dp_cmd_type             cmd,
   output mhpq_pkg::dp_stat_type            stat,
   output logic signed [mhpq_pkg::DATA_W-1:0] res_value,
   output logic [mhpq_pkg::STATUS_W-1:0]    res_status,
   output logic [IW-1:0]                    res_count
);
   import mhpq_pkg::*;

   // one-based store, slot 0 unused
   logic signed [DATA_W-1:0] heap_ff [CAPACITY+1];
   logic signed [DATA_W-1:0] rd_a_ff, rd_b_ff;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic signed [DATA_W-1:0] res_ff, res_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic [IW-1:0]            count_ff, count_in;
   logic [IW-1:0]            pos_ff, pos_in;

   logic [IW:0]              left, right, count_ext;
   logic                     right_ok, best_right;
   logic signed [DATA_W-1:0] best_val;
   logic [IW-1:0]            best_pos;
   logic                     rd_en_a, rd_en_b, wr_en;
   logic [IW-1:0]            rd_addr_a, rd_addr_b;
   logic signed [DATA_W-1:0] wr_data;

   assign left       = {pos_ff, 1'b0};
   assign right      = {pos_ff, 1'b1};
   assign count_ext  = {1'b0, count_ff};
   assign right_ok   = right <= count_ext;
   assign best_right = right_ok && (rd_b_ff > rd_a_ff);
   assign best_val   = best_right ? rd_b_ff : rd_a_ff;
   assign best_pos   = best_right ? right[IW-1:0] : left[IW-1:0];

   assign stat.full     = count_ff == IW'(CAPACITY);
   assign stat.empty    = count_ff == '0;
   assign stat.at_root  = pos_ff == IW'(1);
   assign stat.no_child = left > count_ext;
   assign stat.up_swap  = key_ff > rd_a_ff;
   assign stat.dn_swap  = best_val > key_ff;

   assign rd_en_a   = cmd.start_ext | cmd.rd_up | cmd.rd_down;
   assign rd_en_b   = cmd.start_ext | cmd.rd_down;
   assign rd_addr_a = cmd.start_ext ? IW'(1) :
                      cmd.rd_up     ? (pos_ff >> 1) : left[IW-1:0];
   assign rd_addr_b = cmd.start_ext ? count_ff :
                      right_ok      ? right[IW-1:0] : left[IW-1:0];

   assign wr_en   = cmd.wr_key | cmd.up_move | cmd.dn_move;
   assign wr_data = cmd.up_move ? rd_a_ff : cmd.dn_move ? best_val : key_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_ff[pos_ff] <= wr_data;
      end
      if (rd_en_a) begin
         rd_a_ff <= heap_ff[rd_addr_a];
      end
      if (rd_en_b) begin
         rd_b_ff <= heap_ff[rd_addr_b];
      end
   end

   always_comb begin
      key_in    = key_ff;
      res_in    = res_ff;
      status_in = status_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      if (cmd.start_ins) begin
         key_in    = req_value;
         res_in    = '0;
         status_in = STATUS_OK;
         count_in  = count_ff + IW'(1);
         pos_in    = count_ff + IW'(1);
      end
      if (cmd.set_full) begin
         res_in    = '0;
         status_in = STATUS_FULL;
      end
      if (cmd.set_empty) begin
         res_in    = '0;
         status_in = STATUS_EMPTY;
      end
      if (cmd.ext_load) begin
         res_in    = rd_a_ff;
         key_in    = rd_b_ff;
         status_in = STATUS_OK;
         count_in  = count_ff - IW'(1);
         pos_in    = IW'(1);
      end
      if (cmd.up_move) begin
         pos_in = pos_ff >> 1;
      end
      if (cmd.dn_move) begin
         pos_in = best_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      res_ff    <= res_in;
      status_ff <= status_in;
      pos_ff    <= pos_in;
   end

   assign res_value  = res_ff;
   assign res_status = status_ff;
   assign res_count  = count_ff;

endmodule

>>> rtl/max_heap_priority_queue.sv
// Binary max-heap priority queue of signed 32-bit keys, CAPACITY entries in a
// single-write, dual-read memory with registered read data. Each level of a
// sift is a read step, then a compare-and-write step. One item is worked on
// at a time; a finished item waits in the output register while the next
// one is accepted. No clearing pass after reset. entry_total wraps modulo 256
// for CAPACITY above 255.
`timescale 1ns / 1ps

module max_heap_priority_queue #(
   parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
   input logic           clock,
   input logic           reset,
   mhpq_stream_if.sink   req_if,
   mhpq_stream_if.source rsp_if
);
   import mhpq_pkg::*;

   localparam int IW = $clog2(CAPACITY + 1);

   dp_cmd_type               cmd;
   dp_stat_type              stat;
   logic                     out_load, out_free;
   logic signed [DATA_W-1:0] res_value;
   logic [STATUS_W-1:0]      res_status;
   logic [IW-1:0]            res_count;

   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_item_type             rsp_item_ff, rsp_item_in;

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   mhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_cmd   (req_if.item.cmd),
      .req_ready (req_if.ready),
      .out_free  (out_free),
      .out_load  (out_load),
      .stat      (stat),
      .cmd       (cmd)
   );

   mhpq_datapath #(
      .CAPACITY (CAPACITY),
      .IW       (IW)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_value  (req_if.item.value),
      .cmd        (cmd),
      .stat       (stat),
      .res_value  (res_value),
      .res_status (res_status),
      .res_count  (res_count)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_item_in  = rsp_item_ff;
      if (out_load) begin
         rsp_valid_in             = 1'b1;
         rsp_item_in.result_value = res_value;
         rsp_item_in.status       = res_status;
         rsp_item_in.entry_total  = TOTAL_W'(res_count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.item  = rsp_item_ff;

endmodule

>>> rtl/mhpq_checker.sv
// Port-level checks of the max-heap priority queue, bound to the top level.
// Depends on mhpq_pkg and max_heap_priority_queue_assert.svh.
`timescale 1ns / 1ps
`include "max_heap_priority_queue_assert.svh"

module mhpq_checker #(
   parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [mhpq_pkg::DATA_W-1:0] rsp_result_value,
   input logic [mhpq_pkg::STATUS_W-1:0]      rsp_status,
   input logic [mhpq_pkg::TOTAL_W-1:0]       rsp_entry_total
);
   import mhpq_pkg::*;

   `MHPQ_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid)
   `MHPQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_value) && $stable(rsp_status) && $stable(rsp_entry_total))
   `MHPQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `MHPQ_ASSERT_NOW(a_empty_result, clock, reset, rsp_valid && rsp_status == STATUS_EMPTY, rsp_result_value == '0 && rsp_entry_total == '0)
   `MHPQ_ASSERT_NOW(a_full_result, clock, reset, rsp_valid && rsp_status == STATUS_FULL, rsp_result_value == '0 && rsp_entry_total == TOTAL_W'(CAPACITY))

endmodule

bind max_heap_priority_queue mhpq_checker #(
   .CAPACITY (CAPACITY)
) u_mhpq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_result_value (rsp_if.item.result_value),
   .rsp_status       (rsp_if.item.status),
   .rsp_entry_total  (rsp_if.item.entry_total)
);

>>> tb/tb.sv
// Self-checking testbench for max_heap_priority_queue: directed table, then random
// fill/drain/mixed traffic checked against a behavioral max-heap predictor.
// Depends on mhpq_pkg, mhpq_stream_if and the max_heap_priority_queue RTL.
`timescale 1ns / 1ps

module tb;
   import mhpq_pkg::*;

   localparam int HEAP_CAP       = CAPACITY_DEF;
   localparam int RANDOM_ITEMS   = 450;
   localparam int NUM_CASES      = 23;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 40;

   typedef struct packed {
      logic         fixed;
      rsp_item_type want;
   } item_tag_type;

   typedef struct packed {
      logic              cmd;
      logic [DATA_W-1:0] value;
      item_tag_type      tag;
   } case_row_type;

   logic clock = 1'b0;
   logic reset;
   logic sink_ready = 1'b0;

   mhpq_stream_if #(.item_type(req_item_type)) req_if ();
   mhpq_stream_if #(.item_type(rsp_item_type)) rsp_if ();

   assign rsp_if.ready = sink_ready;

   max_heap_priority_queue #(
      .CAPACITY(HEAP_CAP)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   always #6 clock = ~clock;

   // predictor state
   logic signed [DATA_W-1:0] heap_keys [1:HEAP_CAP];
   int unsigned              heap_count = 0;

   rsp_item_type heap_expect [$];
   item_tag_type item_tags [$];

   int mismatches     = 0;
   int results_seen   = 0;
   int refused_full   = 0;
   int refused_empty  = 0;
   int deepest        = 0;
   int items_sent     = 0;
   int burst_left     = 0;
   int idle_cycles    = 0;

   function automatic rsp_item_type heap_apply(input req_item_type it);
      rsp_item_type             r;
      int unsigned              pos;
      int unsigned              kid;
      logic signed [DATA_W-1:0] tmp;
      r = '0;
      if (it.cmd == CMD_INSERT) begin
         if (heap_count >= HEAP_CAP) begin
            r.status = STATUS_FULL;
         end else begin
            heap_count++;
            pos = heap_count;
            heap_keys[pos] = it.value;
            while (pos > 1) begin
               if (!(heap_keys[pos] > heap_keys[pos / 2])) break;
               tmp = heap_keys[pos];
               heap_keys[pos] = heap_keys[pos / 2];
               heap_keys[pos / 2] = tmp;
               pos = pos / 2;
            end
         end
      end else begin
         if (heap_count == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            r.result_value = heap_keys[1];
            heap_keys[1] = heap_keys[heap_count];
            heap_count--;
            pos = 1;
            while (2 * pos <= heap_count) begin
               kid = 2 * pos;
               if (kid + 1 <= heap_count && heap_keys[kid + 1] > heap_keys[kid]) kid++;
               if (!(heap_keys[kid] > heap_keys[pos])) break;
               tmp = heap_keys[pos];
               heap_keys[pos] = heap_keys[kid];
               heap_keys[kid] = tmp;
               pos = kid;
            end
         end
      end
      r.entry_total = heap_count[TOTAL_W-1:0];
      return r;
   endfunction

   function automatic case_row_type heap_row(input logic cmd, input logic [DATA_W-1:0] value,
                                             input logic fixed, input logic [DATA_W-1:0] rv,
                                             input status_type st, input int total);
      case_row_type row;
      row.cmd                   = cmd;
      row.value                 = value;
      row.tag.fixed             = fixed;
      row.tag.want.result_value = rv;
      row.tag.want.status       = st;
      row.tag.want.entry_total  = total[TOTAL_W-1:0];
      return row;
   endfunction

   function automatic logic [DATA_W-1:0] pick_key();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return '0;
         3:       return '1;
         4, 5, 6: return $urandom_range(0, 12) - 6;
         default: return $urandom();
      endcase
   endfunction

   task automatic flag_result(input string why, input rsp_item_type want,
                              input rsp_item_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%s: expected value %0d status %0d total %0d, got value %0d status %0d total %0d",
                  why, want.result_value, want.status, want.entry_total,
                  got.result_value, got.status, got.entry_total);
   endtask

   // Bursty sender: returns at the edge where the item is accepted.
   task automatic offer(input logic cmd, input logic [DATA_W-1:0] value,
                        input item_tag_type tag);
      int           gap;
      req_item_type it;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      it.cmd   = cmd;
      it.value = value;
      item_tags.push_back(tag);
      req_if.item  <= it;
      req_if.valid <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
   endtask

   // result checker and predictor
   always @(posedge clock) begin : check_results
      rsp_item_type want;
      rsp_item_type got;
      item_tag_type tag;
      rsp_item_type pred;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.item;
            results_seen++;
            if (heap_expect.size() == 0) begin
               flag_result("unexpected result", '0, got);
            end else begin
               want = heap_expect.pop_front();
               if (got.result_value !== want.result_value || got.status !== want.status ||
                   got.entry_total !== want.entry_total)
                  flag_result("mismatch", want, got);
            end
         end
         if (req_if.valid && req_if.ready) begin
            tag  = item_tags.pop_front();
            pred = heap_apply(req_if.item);
            if (pred.status == STATUS_FULL) refused_full++;
            if (pred.status == STATUS_EMPTY) refused_empty++;
            if (heap_count > deepest) deepest = heap_count;
            heap_expect.push_back(tag.fixed ? tag.want : pred);
         end
      end
   end

   // receiver stall pattern with two long hold-offs
   logic [15:0] stall_tick;
   logic [1:0]  stall_mode;
   int          hold_left;
   int          taken_here;

   always @(posedge clock) begin
      if (reset) begin
         sink_ready <= 1'b0;
         stall_tick <= '0;
         stall_mode <= '0;
         hold_left  <= 0;
         taken_here <= 0;
      end else begin
         stall_tick <= stall_tick + 1'b1;
         if (stall_tick[5:0] == 6'd0) stall_mode <= 2'($urandom_range(0, 3));
         if (rsp_if.valid && rsp_if.ready) taken_here <= taken_here + 1;
         if (hold_left != 0) begin
            sink_ready <= 1'b0;
            hold_left  <= hold_left - 1;
         end else if (rsp_if.valid && rsp_if.ready && (taken_here == 99 || taken_here == 319)) begin
            sink_ready <= 1'b0;
            hold_left  <= LONG_HOLD;
         end else begin
            case (stall_mode)
               2'd0:    sink_ready <= 1'b1;
               2'd1:    sink_ready <= 1'($urandom_range(0, 1));
               2'd2:    sink_ready <= ($urandom_range(0, 3) == 0);
               default: sink_ready <= (stall_tick[1:0] != 2'd0);
            endcase
         end
      end
   end

   // no-progress watchdog
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      case_row_type heap_cases [0:NUM_CASES-1];
      item_tag_type open_tag;
      int           ins_pct;

      req_if.valid = 1'b0;
      req_if.item  = '0;
      reset        = 1'b1;
      open_tag     = '0;

      heap_cases = '{
         heap_row(CMD_EXTRACT, 32'h0000_0000, 1'b1, 32'd0,        STATUS_EMPTY, 0),
         heap_row(CMD_INSERT,  32'h0000_0000, 1'b1, 32'd0,        STATUS_OK,    1),
         heap_row(CMD_INSERT,  32'h7FFF_FFFF, 1'b1, 32'd0,        STATUS_OK,    2),
         heap_row(CMD_INSERT,  32'h8000_0000, 1'b1, 32'd0,        STATUS_OK,    3),
         heap_row(CMD_INSERT,  32'hFFFF_FFFF, 1'b1, 32'd0,        STATUS_OK,    4),
         heap_row(CMD_INSERT,  32'h0000_0001, 1'b0, 32'd0,        STATUS_OK,    0),
         heap_row(CMD_INSERT,  32'hFFFF_FFFF, 1'b0, 32'd0,        STATUS_OK,    0),
         heap_row(CMD_EXTRACT, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, STATUS_OK,   5),
         heap_row(CMD_EXTRACT, 32'h0000_0000, 1'b0, 32'd0,        STATUS_OK,    0),
         heap_row(CMD_EXTRACT, 32'hAAAA_5555, 1'b0, 32'd0,        STATUS_OK,    0),
         heap_row(CMD_EXTRACT, 32'h5555_AAAA, 1'b0, 32'd0,        STATUS_OK,    0),
         heap_row(CMD_EXTRACT, 32'h0000_0000, 1'b0, 32'd0,        STATUS_OK,    0),
         heap_row(CMD_EXTRACT, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, STATUS_OK,   0),
         heap_row(CMD_EXTRACT, 32'hFFFF_FFFF, 1'b1, 32'd0,        STATUS_EMPTY, 0),
         heap_row(CMD_INSERT,  32'h0000_0005, 1'b0, 32'd0,        STATUS_OK,    0),
         heap_row(CMD_INSERT,  32'h0000_0005, 1'b0, 32'd0,        STATUS_OK,    0),
         heap_row(CMD_INSERT,  32'h8000_0000, 1'b0, 32'd0,        STATUS_OK,    0),
         heap_row(CMD_INSERT,  32'h0000_0005, 1'b0, 32'd0,        STATUS_OK,    0),
         heap_row(CMD_EXTRACT, 32'h0000_0000, 1'b0, 32'd0,        STATUS_OK,    0),
         heap_row(CMD_EXTRACT, 32'h0000_0000, 1'b0, 32'd0,        STATUS_OK,    0),
         heap_row(CMD_EXTRACT, 32'h0000_0000, 1'b0, 32'd0,        STATUS_OK,    0),
         heap_row(CMD_EXTRACT, 32'h0000_0000, 1'b0, 32'd0,        STATUS_OK,    0),
         heap_row(CMD_EXTRACT, 32'h0000_0000, 1'b1, 32'd0,        STATUS_EMPTY, 0)
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (heap_cases[i])
         offer(heap_cases[i].cmd, heap_cases[i].value, heap_cases[i].tag);

      // fill past capacity, drain past empty, then mixed traffic
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n < 135)      ins_pct = 100;
         else if (n < 295) ins_pct = 8;
         else if (n < 375) ins_pct = 60;
         else              ins_pct = 40;
         if ($urandom_range(1, 100) <= ins_pct)
            offer(CMD_INSERT, pick_key(), open_tag);
         else
            offer(CMD_EXTRACT, $urandom(), open_tag);
      end
      req_if.valid <= 1'b0;

      while (heap_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d items sent, %0d results checked, %0d mismatches", items_sent,
               results_seen, mismatches);
      $display("heap peaked at %0d entries; %0d inserts refused as full, %0d extracts as empty",
               deepest, refused_full, refused_empty);
      if (mismatches == 0 && heap_expect.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
